// File: sv/ssi_pkg.sv
// Shared constants, types and helpers of the shaped segment interpolator.
package ssi_pkg;

  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAX_WAVE_CYCLES_DEF = 64;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [16:0] LEVEL_MAX = 17'd65536;

  // Odd sine series, highest order first; SIN_C9 seeds the Horner chain.
  localparam logic [31:0] SIN_C9 = 32'd172272;
  localparam logic [31:0] SIN_COEF [0:3] = '{32'd5026995, 32'd85569305, 32'd693598668,
                                              32'd1686629713};

  typedef enum logic [2:0] {
    KIND_KEEP   = 3'd0,
    KIND_EXP    = 3'd1,
    KIND_SINE   = 3'd2,
    KIND_TRI    = 3'd3,
    KIND_SQUARE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [15:0] position;
    logic [16:0] level_start;
    logic [16:0] level_end;
    logic [15:0] shape_amount;
    logic [2:0]  shape_kind;
  } item_t;

  // Move an unsigned Q(src) value to Q(fb), rounding half up.
  function automatic logic [63:0] to_frac(input logic [63:0] v, input int src, input int fb);
    if (fb >= src) return v << (fb - src);
    return (v + (64'd1 << (src - fb - 1))) >> (src - fb);
  endfunction

endpackage

// File: sv/shaped_segment_interpolator.sv
// Shaped curve segment point evaluator: fully pipelined, one item per clock unless the output stalls.
// Throughput: one item per cycle; every stage advances together, and the whole
// pipeline holds while the output register carries a result not yet taken.
// The exponential path sets the depth: three e^-y units with an eleven-step
// Horner chain, then a FRAC_BITS+2 step restoring divider.
// Reset (rst, synchronous, active high) clears only the stage valid bits.
module shaped_segment_interpolator #(
  parameter int FRAC_BITS       = ssi_pkg::FRAC_BITS_DEF,
  parameter int MAX_WAVE_CYCLES = ssi_pkg::MAX_WAVE_CYCLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position[15:0], level_start[32:16], level_end[49:33], shape_amount[65:50], zero fill
  input  logic [71:0] s_axis_tdata,
  // shape_kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // level_out[16:0], zero fill
  output logic [23:0] m_axis_tdata
);
  import ssi_pkg::*;

  localparam int FB  = FRAC_BITS;
  localparam int FW  = FB + 1;        // fraction width, holds 1.0
  localparam int QB  = FB + 2;        // quotient bits of the divider
  localparam int DW  = FB + 32;       // dividend width
  localparam int PW  = FB + 20;       // product width of the final mix
  localparam logic [FW-1:0] F_ONE = {1'b1, {FB{1'b0}}};
  localparam logic [8:0] MWC   = 9'(MAX_WAVE_CYCLES);
  localparam logic [8:0] MWCM1 = 9'(MAX_WAVE_CYCLES - 1);
  localparam logic signed [PW-1:0] RND = PW'(1) << (FB - 1);

  // Stage numbers.
  localparam int ST_E    = 37;
  localparam int ST_ND   = 38;
  localparam int ST_FX   = ST_ND + QB + 1;
  localparam int ST_F    = ST_FX + 1;
  localparam int ST_PROD = ST_F + 1;
  localparam int NST     = ST_PROD + 2;
  localparam int W_F     = 9;

  logic           adv;
  logic [NST-1:0] v;
  item_t          cr [ST_PROD+1];

  assign adv           = !v[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v[NST-1];

  // Valid bits and side data advance together.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr[0].position     <= s_axis_tdata[15:0];
      cr[0].level_start  <= s_axis_tdata[32:16];
      cr[0].level_end    <= s_axis_tdata[49:33];
      cr[0].shape_amount <= s_axis_tdata[65:50];
      cr[0].shape_kind   <= s_axis_tuser;
      for (int i = 1; i <= ST_PROD; i++) cr[i] <= cr[i-1];
    end
  end

  // ---------------- Exponential path ----------------
  // Stage 1: K = 40|A| and Kx = round(20|A|p / 2^15), both Q16.
  logic [15:0] mag_c;
  logic [19:0] mag20_c;
  logic [36:0] kxp_c;
  logic [20:0] xk, xkx;

  assign mag_c   = cr[0].shape_amount[15] ? 16'(~cr[0].shape_amount + 16'd1)
                                          : cr[0].shape_amount;
  assign mag20_c = 20'(mag_c) * 20'd20;
  assign kxp_c   = 37'(mag20_c) * 37'(cr[0].position) + 37'd16384;

  always_ff @(posedge clk) begin
    if (adv) begin
      xk  <= 21'(mag_c) * 21'd40;
      xkx <= kxp_c[35:15];
    end
  end

  // Stage 2: z = round(y log2 e) for y = K, Kx and K - Kx.
  logic [20:0] y_c  [3];
  logic [52:0] zp_c [3];
  logic [21:0] xz   [3];

  assign y_c[0] = xk;
  assign y_c[1] = xkx;
  assign y_c[2] = xk - xkx;

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      zp_c[u] = 53'(y_c[u]) * 53'(LOG2E_Q30) + (53'd1 << 29);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int u = 0; u < 3; u++) xz[u] <= zp_c[u][51:30];
    end
  end

  // Stage 3: split z into whole shift and residual r = frac(z) ln 2 in Q30.
  logic [45:0] rp_c   [3];
  logic [29:0] hc_r   [11][3];
  logic [5:0]  hc_w   [12][3];
  logic [30:0] hc_acc [12][3];
  logic [30:0] ha_q   [11][3];
  logic [29:0] ha_r   [11][3];
  logic [5:0]  ha_w   [11][3];
  logic [30:0] hb_q   [11][3];
  logic [30:0] hb_e   [11][3];
  logic [29:0] hb_r   [11][3];
  logic [5:0]  hb_w   [11][3];

  always_comb begin
    for (int u = 0; u < 3; u++) rp_c[u] = 46'(xz[u][15:0]) * 46'(LN2_Q30);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int u = 0; u < 3; u++) begin
        hc_r[0][u]   <= rp_c[u][45:16];
        hc_w[0][u]   <= xz[u][21:16];
        hc_acc[0][u] <= Q30_ONE;
      end
    end
  end

  // Horner steps acc = 1 - (r acc) / n for n = 11 down to 1, three stages each:
  // multiply, reciprocal estimate, remainder correction.
  for (genvar j = 0; j < 11; j++) begin : g_horner
    localparam int N = 11 - j;
    localparam logic [33:0] RECIP = 34'((64'd1 << 33) / N);
    logic [60:0] pa  [3];
    logic [64:0] pb  [3];
    logic [35:0] rem [3];
    logic [30:0] quo [3];

    always_comb begin
      for (int u = 0; u < 3; u++) begin
        pa[u]  = 61'(hc_r[j][u]) * 61'(hc_acc[j][u]);
        pb[u]  = 65'(ha_q[j][u]) * 65'(RECIP);
        rem[u] = 36'(hb_q[j][u]) - 36'(hb_e[j][u]) * 36'(N);
        quo[u] = hb_e[j][u] + ((rem[u] >= 36'(N)) ? 31'd1 : 31'd0);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int u = 0; u < 3; u++) begin
          ha_q[j][u]     <= pa[u][60:30];
          ha_r[j][u]     <= hc_r[j][u];
          ha_w[j][u]     <= hc_w[j][u];
          hb_q[j][u]     <= ha_q[j][u];
          hb_e[j][u]     <= pb[u][63:33];
          hb_r[j][u]     <= ha_r[j][u];
          hb_w[j][u]     <= ha_w[j][u];
          hc_acc[j+1][u] <= Q30_ONE - quo[u];
          hc_w[j+1][u]   <= hb_w[j][u];
        end
      end
    end

    if (j < 10) begin : g_rfwd
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int u = 0; u < 3; u++) hc_r[j+1][u] <= hb_r[j][u];
        end
      end
    end
  end

  // Apply the power-of-two part of e^-y.
  logic [30:0] xe [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int u = 0; u < 3; u++) begin
        xe[u] <= (hc_w[11][u] >= 6'd31) ? 31'd0 : (hc_acc[11][u] >> hc_w[11][u]);
      end
    end
  end

  // Numerator and denominator; detect fallback and overflow of the quotient.
  logic [30:0]   den_c, num_c;
  logic [31:0]   npos_c;
  logic [DW-1:0] d_c;
  logic          fb_c, sat_c;
  logic [15:0]   amt_e;

  assign amt_e  = cr[ST_E].shape_amount;
  assign den_c  = Q30_ONE - xe[0];
  assign npos_c = {1'b0, xe[2]} - {1'b0, xe[0]};
  assign num_c  = amt_e[15] ? (Q30_ONE - xe[1]) : (npos_c[31] ? 31'd0 : npos_c[30:0]);
  assign d_c    = (DW'(num_c) << FB) + DW'(den_c >> 1);
  assign sat_c  = {1'b0, num_c} >= {den_c, 1'b0};
  assign fb_c   = (amt_e == 16'd0) || (amt_e == 16'd1) || (amt_e == 16'hFFFF)
                  || (den_c == 31'd0);

  logic [30:0]   dv_rem [QB];
  logic [QB-1:0] dv_lo  [QB];
  logic [30:0]   dv_den [QB];
  logic [QB-1:0] dv_q   [QB+1];
  logic          dv_fb  [QB+1];
  logic          dv_sat [QB+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= 31'(d_c[DW-1:QB]);
      dv_lo[0]  <= d_c[QB-1:0];
      dv_den[0] <= den_c;
      dv_q[0]   <= '0;
      dv_fb[0]  <= fb_c;
      dv_sat[0] <= sat_c;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [31:0] trial;
    logic        ge;

    assign trial = {dv_rem[i], dv_lo[i][QB-1-i]};
    assign ge    = trial >= {1'b0, dv_den[i]};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_q[i+1]   <= {dv_q[i][QB-2:0], ge};
        dv_fb[i+1]  <= dv_fb[i];
        dv_sat[i+1] <= dv_sat[i];
      end
    end

    if (i < QB - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[i+1] <= ge ? 31'(trial - {1'b0, dv_den[i]}) : trial[30:0];
          dv_lo[i+1]  <= dv_lo[i];
          dv_den[i+1] <= dv_den[i];
        end
      end
    end
  end

  // Select the exponential fraction: linear fallback, the quotient clamped to 1.0, or the quotient.
  logic [FW-1:0] fexp;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_fb[QB]) begin
        fexp <= FW'(to_frac(64'(cr[ST_FX-1].position), 16, FB));
      end else if (dv_sat[QB] || (dv_q[QB] > QB'(F_ONE))) begin
        fexp <= F_ONE;
      end else begin
        fexp <= dv_q[QB][FW-1:0];
      end
    end
  end

  // ---------------- Wave path ----------------
  // Stage 1: cycle counts from the amount.
  logic [15:0] m_c;
  logic [24:0] np_c, sqp_c;
  logic [8:0]  wn, wsq;

  assign m_c   = {~cr[0].shape_amount[15], cr[0].shape_amount[14:0]};
  assign np_c  = 25'(m_c) * 25'(MWC) + 25'd32768;
  assign sqp_c = 25'(m_c) * 25'(MWCM1) + 25'd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      wn  <= np_c[24:16];
      wsq <= sqp_c[24:16] + 9'd1;
    end
  end

  // Stage 2: phase, fold to half a turn, triangle and square values.
  logic [25:0]   tp_c;
  logic [24:0]   qp_c;
  logic [16:0]   t_c, tf_c;
  logic [17:0]   tr_c;
  logic          hi_c;
  logic [15:0]   wq;
  logic          whi  [2:8];
  logic [FW-1:0] wtri [2:8];
  logic          wsqb [2:8];

  assign tp_c = 26'({wn, 1'b1}) * 26'(cr[1].position);
  assign qp_c = 25'(wsq) * 25'(cr[1].position);
  assign t_c  = tp_c[16:0];
  assign tr_c = 18'd131072 - 18'(t_c);
  assign tf_c = (t_c > 17'd65536) ? tr_c[16:0] : t_c;
  assign hi_c = tf_c > 17'd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      wq      <= hi_c ? 16'(tf_c - 17'd32768) : 16'(17'd32768 - tf_c);
      whi[2]  <= hi_c;
      wtri[2] <= FW'(to_frac(64'(tf_c), 16, FB));
      wsqb[2] <= qp_c[15];
      for (int s = 3; s <= 8; s++) begin
        whi[s]  <= whi[s-1];
        wtri[s] <= wtri[s-1];
        wsqb[s] <= wsqb[s-1];
      end
    end
  end

  // Stage 3: z and z^2 for the quarter-wave sine.
  logic [30:0] z_c;
  logic [61:0] z2p_c;
  logic [30:0] wz   [3:7];
  logic [30:0] wz2  [3:6];
  logic [31:0] wacc [3:7];

  assign z_c   = {wq, 15'd0};
  assign z2p_c = 62'(z_c) * 62'(z_c);

  always_ff @(posedge clk) begin
    if (adv) begin
      wz[3]   <= z_c;
      wz2[3]  <= z2p_c[60:30];
      wacc[3] <= SIN_C9;
    end
  end

  // Sine Horner steps, one multiply per stage.
  for (genvar k = 0; k < 4; k++) begin : g_sin
    logic [62:0] sp;
    logic [32:0] sd;

    assign sp = 63'(wacc[3+k]) * 63'(wz2[3+k]);
    assign sd = 33'(SIN_COEF[k]) - sp[62:30];

    always_ff @(posedge clk) begin
      if (adv) begin
        wacc[4+k] <= sd[31:0];
        wz[4+k]   <= wz[3+k];
      end
    end

    if (k < 3) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) wz2[4+k] <= wz2[3+k];
      end
    end
  end

  logic [62:0] fsp_c;
  logic [31:0] ws;

  assign fsp_c = 63'(wacc[7]) * 63'(wz[7]);

  always_ff @(posedge clk) begin
    if (adv) ws <= fsp_c[61:30];
  end

  // Stage 9: raised cosine, clamp, and shape select for the non-exponential kinds.
  logic signed [33:0] f31_c;
  logic [31:0]        f31c_c;
  logic [FW-1:0]      fsin_c, fwav_c;
  logic [FW-1:0]      fw [W_F:ST_FX];

  assign f31_c = whi[8] ? (34'(Q30_ONE) + 34'(ws)) : (34'(Q30_ONE) - 34'(ws));

  always_comb begin
    if (f31_c < 0) begin
      f31c_c = 32'd0;
    end else if (f31_c > 34'sh8000_0000) begin
      f31c_c = 32'h8000_0000;
    end else begin
      f31c_c = f31_c[31:0];
    end
    fsin_c = FW'(to_frac(64'(f31c_c), 31, FB));
    case (cr[8].shape_kind)
      KIND_SINE:   fwav_c = fsin_c;
      KIND_TRI:    fwav_c = wtri[8];
      KIND_SQUARE: fwav_c = wsqb[8] ? F_ONE : '0;
      default:     fwav_c = '0;
    endcase
  end

  // Hold the wave fraction until the exponential path catches up.
  always_ff @(posedge clk) begin
    if (adv) begin
      fw[W_F] <= fwav_c;
      for (int s = W_F + 1; s <= ST_FX; s++) fw[s] <= fw[s-1];
    end
  end

  // ---------------- Join and final mix ----------------
  logic [FW-1:0]         ff;
  logic signed [17:0]    diff_c;
  logic signed [FW:0]    fs_c;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  rnd_c, sh_c;
  logic signed [21:0]    res_c;
  logic [16:0]           level_out;

  always_ff @(posedge clk) begin
    if (adv) ff <= (cr[ST_F-1].shape_kind == KIND_EXP) ? fexp : fw[ST_FX];
  end

  assign diff_c = $signed({1'b0, cr[ST_F].level_end}) - $signed({1'b0, cr[ST_F].level_start});
  assign fs_c   = $signed({1'b0, ff});

  always_ff @(posedge clk) begin
    if (adv) prod <= PW'(diff_c) * PW'(fs_c);
  end

  // Round half up at 2^-FRAC_BITS, add the start level, saturate to 0..1.
  assign rnd_c = prod + RND;
  assign sh_c  = rnd_c >>> FB;
  assign res_c = 22'(sh_c) + $signed({5'd0, cr[ST_PROD].level_start});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (res_c < 0) begin
        level_out <= '0;
      end else if (res_c > $signed({5'd0, LEVEL_MAX})) begin
        level_out <= LEVEL_MAX;
      end else begin
        level_out <= res_c[16:0];
      end
    end
  end

  assign m_axis_tdata = {7'd0, level_out};

  // ---------------- Assertions ----------------
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> level_out <= LEVEL_MAX)
    else $error("level_out above full scale");

  a_exp_frac: assert property (@(posedge clk) disable iff (rst)
    v[ST_FX] |-> fexp <= F_ONE)
    else $error("exponential fraction above one");

  a_wave_frac: assert property (@(posedge clk) disable iff (rst)
    v[W_F] |-> fw[W_F] <= F_ONE)
    else $error("wave fraction above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> v == $past(v))
    else $error("pipeline moved during stall");

endmodule
